// ===== design/fwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fwbc_pkg: shared types for the FIFO write-back cache
// Command and result codes, the transfer payloads and the control and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fwbc_pkg;

  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 64;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_MISS = 2'd1,
    KIND_DONE = 2'd2,
    KIND_WB   = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t               command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   out_key;
    logic [VALUE_W-1:0] out_value;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_in;    // capture the accepted request, clear the age counter
    logic  age_inc;    // step to the next entry by age
    logic  rd_en;      // read key and value memories
    logic  rd_oldest;  // read at the oldest slot instead of the age slot
    logic  store_hit;  // write value at the matched slot and mark it dirty
    logic  append;     // write a new entry at the tail
    logic  evict_pop;  // drop the oldest entry
    logic  flush_clr;  // clear the dirty mark of the slot just read
    logic  flush_end;  // empty the cache
    logic  out_load;   // load the result register
    kind_t out_kind;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic at_end;      // age counter has reached the entry count
    logic key_match;   // key just read equals the request key
    logic need_evict;  // cache is at capacity
    logic dirty_sel;   // dirty mark of the slot just read
    logic out_free;    // result register can take a new result
  } stat_t;

endpackage

// ===== design/fifo_writeback_cache_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_writeback_cache_unit: fully associative FIFO write-back cache
// Get, set, fill and flush requests against a ring of entries; dirty
// victims and dirty flushed entries are reported as write-back results.
//
//   channel  signals                        payload
//   in       in_valid / in_ready            in_item  (command, key, value)
//   out      out_valid / out_ready          out_item (kind, out_key, out_value, last)
//   cfg      cfg_valid / cfg_ready          cfg_data (capacity_in_use)
//
// A lookup reads the entries one at a time, oldest first. A get miss ends
// after the walk; a set or fill miss then appends at the tail, first evicting
// the oldest entries while the cache is at capacity. A flush reads every
// entry. A new request is taken once the sequencer is back in idle after the
// final result is loaded. Reset empties the cache and sets the capacity to 16.
// A request is taken while its predecessor's final result still waits;
// a result that cannot be transferred holds the sequencer in place.
// ----------------------------------------------------------------------------
module fifo_writeback_cache_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fwbc_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fwbc_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fwbc_pkg::CAP_W-1:0] cfg_data
);

  fwbc_pkg::ctrl_t ctrl;
  fwbc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  fwbc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== design/fwbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwbc_ctrl: request sequencer
// Walks the entry ring for lookups, evictions and flushes, and decides
// which result is emitted at each step.
// ----------------------------------------------------------------------------
module fwbc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fwbc_pkg::stat_t stat,
  output fwbc_pkg::ctrl_t ctrl
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOOK  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_EVCHK = 8'b0000_1000,
    S_EVICT = 8'b0001_0000,
    S_FLCHK = 8'b0010_0000,
    S_FLUSH = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl          = '0;
    ctrl.out_kind = fwbc_pkg::KIND_DONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_LOOK;
        end
      end
      S_LOOK: begin
        // The flush command shares the entry walk but has its own states.
        if (stat.cmd == fwbc_pkg::CMD_FLUSH) begin
          state_next = S_FLCHK;
        end else if (!stat.at_end) begin
          ctrl.rd_en = 1'b1;
          state_next = S_CMP;
        end else if (stat.cmd != fwbc_pkg::CMD_GET) begin
          state_next = S_EVCHK;
        end else if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          ctrl.out_kind = fwbc_pkg::KIND_MISS;
          state_next    = S_IDLE;
        end
      end
      S_CMP: begin
        if (!stat.key_match) begin
          ctrl.age_inc = 1'b1;
          state_next   = S_LOOK;
        end else if (stat.out_free) begin
          ctrl.out_load  = 1'b1;
          ctrl.store_hit = (stat.cmd == fwbc_pkg::CMD_SET);
          ctrl.out_kind  = (stat.cmd == fwbc_pkg::CMD_GET) ? fwbc_pkg::KIND_HIT
                                                          : fwbc_pkg::KIND_DONE;
          state_next     = S_IDLE;
        end
      end
      S_EVCHK: begin
        if (stat.need_evict) begin
          ctrl.rd_en     = 1'b1;
          ctrl.rd_oldest = 1'b1;
          state_next     = S_EVICT;
        end else if (stat.out_free) begin
          ctrl.append   = 1'b1;
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_EVICT: begin
        if (!stat.dirty_sel || stat.out_free) begin
          ctrl.out_load  = stat.dirty_sel;
          ctrl.out_kind  = fwbc_pkg::KIND_WB;
          ctrl.evict_pop = 1'b1;
          state_next     = S_EVCHK;
        end
      end
      S_FLCHK: begin
        if (!stat.at_end) begin
          ctrl.rd_en = 1'b1;
          state_next = S_FLUSH;
        end else if (stat.out_free) begin
          ctrl.flush_end = 1'b1;
          ctrl.out_load  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!stat.dirty_sel || stat.out_free) begin
          ctrl.out_load  = stat.dirty_sel;
          ctrl.out_kind  = fwbc_pkg::KIND_WB;
          ctrl.flush_clr = 1'b1;
          ctrl.age_inc   = 1'b1;
          state_next     = S_FLCHK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fwbc_datapath.sv =====
// ----------------------------------------------------------------------------
// fwbc_datapath: entry storage and result register
// Key and value memories used as a ring, dirty marks, occupancy, the
// capacity register and the registered result.
// ----------------------------------------------------------------------------
module fwbc_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fwbc_pkg::in_item_t             in_item,
  input  logic                           cfg_valid,
  input  logic [fwbc_pkg::CAP_W-1:0]     cfg_data,
  input  fwbc_pkg::ctrl_t                ctrl,
  output fwbc_pkg::stat_t                stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fwbc_pkg::out_item_t            out_item
);

  localparam int KW     = (KEY_BITS < fwbc_pkg::KEY_W) ? KEY_BITS : fwbc_pkg::KEY_W;
  localparam int VW     = VALUE_BITS;
  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = CNT_W + 1;

  logic [KW-1:0]              key_mem [MAX_ENTRIES];
  logic [VW-1:0]              val_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     dirty;
  logic [SLOT_W-1:0]          oldest;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           age;
  logic [fwbc_pkg::CAP_W-1:0] cap;
  logic [CNT_W-1:0]           eff_cap;

  fwbc_pkg::cmd_t             cur_cmd;
  logic [KW-1:0]              cur_key;
  logic [VW-1:0]              cur_value;

  logic [KW-1:0]              rd_key;
  logic [VW-1:0]              rd_value;
  logic [SLOT_W-1:0]          rd_slot;

  logic [SLOT_W-1:0]          age_slot;
  logic [SLOT_W-1:0]          app_slot;
  logic [SLOT_W-1:0]          raddr;
  logic [SLOT_W-1:0]          waddr;
  logic                       out_free;

  // Ring position: base plus offset, wrapped once; offset is at most the depth.
  function automatic logic [SLOT_W-1:0] wrap_add(logic [SLOT_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(MAX_ENTRIES)) begin
      s = s - SUM_W'(MAX_ENTRIES);
    end
    return s[SLOT_W-1:0];
  endfunction

  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap) > MAX_ENTRIES) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign age_slot = wrap_add(oldest, age);
  assign app_slot = wrap_add(oldest, count);
  assign raddr    = ctrl.rd_oldest ? oldest : age_slot;
  assign waddr    = ctrl.append ? app_slot : rd_slot;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat            = '0;
    stat.cmd        = cur_cmd;
    stat.at_end     = (age == count);
    stat.key_match  = (rd_key == cur_key);
    stat.need_evict = (count != '0) && (count >= eff_cap);
    stat.dirty_sel  = dirty[rd_slot];
    stat.out_free   = out_free;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cur_cmd   <= in_item.command;
      cur_key   <= in_item.key[KW-1:0];
      cur_value <= in_item.value[VW-1:0];
    end
  end

  // Entry memories with registered read.
  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      key_mem[waddr] <= cur_key;
    end
    if (ctrl.append || ctrl.store_hit) begin
      val_mem[waddr] <= cur_value;
    end
    if (ctrl.rd_en) begin
      rd_key   <= key_mem[raddr];
      rd_value <= val_mem[raddr];
      rd_slot  <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty  <= '0;
      oldest <= '0;
      count  <= '0;
      age    <= '0;
      cap    <= fwbc_pkg::CAP_W'(fwbc_pkg::CAP_RESET);
    end else begin
      if (cfg_valid) begin
        cap <= cfg_data;
      end
      if (ctrl.load_in) begin
        age <= '0;
      end else if (ctrl.age_inc) begin
        age <= age + CNT_W'(1);
      end
      if (ctrl.append) begin
        dirty[app_slot] <= (cur_cmd == fwbc_pkg::CMD_SET);
        count           <= count + CNT_W'(1);
      end
      if (ctrl.store_hit) begin
        dirty[rd_slot] <= 1'b1;
      end
      if (ctrl.evict_pop) begin
        dirty[rd_slot] <= 1'b0;
        oldest         <= wrap_add(oldest, CNT_W'(1));
        count          <= count - CNT_W'(1);
      end
      if (ctrl.flush_clr) begin
        dirty[rd_slot] <= 1'b0;
      end
      if (ctrl.flush_end) begin
        oldest <= '0;
        count  <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_item.kind <= ctrl.out_kind;
      out_item.last <= (ctrl.out_kind != fwbc_pkg::KIND_WB);
      unique case (ctrl.out_kind)
        fwbc_pkg::KIND_HIT: begin
          out_item.out_key   <= fwbc_pkg::KEY_W'(cur_key);
          out_item.out_value <= fwbc_pkg::VALUE_W'(rd_value);
        end
        fwbc_pkg::KIND_MISS: begin
          out_item.out_key   <= fwbc_pkg::KEY_W'(cur_key);
          out_item.out_value <= '0;
        end
        fwbc_pkg::KIND_WB: begin
          out_item.out_key   <= fwbc_pkg::KEY_W'(rd_key);
          out_item.out_value <= fwbc_pkg::VALUE_W'(rd_value);
        end
        default: begin
          out_item.out_key   <= '0;
          out_item.out_value <= '0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds the ring depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.append |-> (count < eff_cap))
    else $error("append issued with the cache at capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> out_free)
    else $error("result register loaded while a result is still pending");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush_end |=> (count == '0) && (oldest == '0))
    else $error("cache not empty after flush");

endmodule

// ===== bench/fwbc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwbc_checker: result predictor and scoreboard for the write-back cache
// Watches the request, result and configuration channels of the cache.
// It keeps its own ring of entries, works out the results of each accepted
// request, and checks every result transfer against the oldest one due.
// ----------------------------------------------------------------------------
module fwbc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  fwbc_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  fwbc_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fwbc_pkg::CAP_W-1:0]     cfg_data,
  output int unsigned                    errors,
  output int unsigned                    outstanding
);

  localparam int SLOTS = 16;

  logic [fwbc_pkg::KEY_W-1:0]   cache_keys   [SLOTS];
  logic [fwbc_pkg::VALUE_W-1:0] cache_values [SLOTS];
  logic                         cache_dirty  [SLOTS];
  logic [3:0]                   ring_head;
  logic [4:0]                   ring_count;
  logic [fwbc_pkg::CAP_W-1:0]   capacity_reg;
  fwbc_pkg::out_item_t          due_results [$];

  initial errors = 0;
  initial outstanding = 0;

  function automatic void queue_result(fwbc_pkg::kind_t k,
                                       logic [fwbc_pkg::KEY_W-1:0] key,
                                       logic [fwbc_pkg::VALUE_W-1:0] value,
                                       logic last);
    fwbc_pkg::out_item_t r;
    r.kind      = k;
    r.out_key   = key;
    r.out_value = value;
    r.last      = last;
    due_results.push_back(r);
  endfunction

  // Searches the valid entries, oldest first.
  function automatic int find_entry(logic [fwbc_pkg::KEY_W-1:0] key);
    logic [3:0] slot;
    for (int age = 0; age < ring_count; age++) begin
      slot = ring_head + age[3:0];
      if (cache_keys[slot] == key) return int'(slot);
    end
    return -1;
  endfunction

  // Evicts the oldest entries while the cache is full, then adds one at the tail.
  function automatic void add_entry(logic [fwbc_pkg::KEY_W-1:0] key,
                                    logic [fwbc_pkg::VALUE_W-1:0] value,
                                    logic dirty);
    int         limit;
    logic [3:0] tail;
    limit = (capacity_reg == 0) ? 1
          : ((int'(capacity_reg) > SLOTS) ? SLOTS : int'(capacity_reg));
    while (ring_count != 0 && int'(ring_count) >= limit) begin
      if (cache_dirty[ring_head])
        queue_result(fwbc_pkg::KIND_WB, cache_keys[ring_head], cache_values[ring_head],
                     1'b0);
      cache_dirty[ring_head] = 1'b0;
      ring_head  = ring_head + 4'd1;
      ring_count = ring_count - 5'd1;
    end
    tail = ring_head + ring_count[3:0];
    cache_keys[tail]   = key;
    cache_values[tail] = value;
    cache_dirty[tail]  = dirty;
    ring_count = ring_count + 5'd1;
  endfunction

  function automatic void predict_request(fwbc_pkg::in_item_t req);
    int         slot;
    logic [3:0] walk;
    slot = find_entry(req.key);
    if (req.command == fwbc_pkg::CMD_GET) begin
      if (slot >= 0) queue_result(fwbc_pkg::KIND_HIT, req.key, cache_values[slot], 1'b1);
      else queue_result(fwbc_pkg::KIND_MISS, req.key, '0, 1'b1);
    end else begin
      case (req.command)
        fwbc_pkg::CMD_SET: begin
          if (slot >= 0) begin
            cache_values[slot] = req.value;
            cache_dirty[slot]  = 1'b1;
          end else begin
            add_entry(req.key, req.value, 1'b1);
          end
        end
        fwbc_pkg::CMD_FILL: begin
          if (slot < 0) add_entry(req.key, req.value, 1'b0);
        end
        default: begin
          for (int age = 0; age < ring_count; age++) begin
            walk = ring_head + age[3:0];
            if (cache_dirty[walk])
              queue_result(fwbc_pkg::KIND_WB, cache_keys[walk], cache_values[walk], 1'b0);
            cache_dirty[walk] = 1'b0;
          end
          ring_count = '0;
          ring_head  = '0;
        end
      endcase
      queue_result(fwbc_pkg::KIND_DONE, '0, '0, 1'b1);
    end
  endfunction

  function automatic void report_field(string field, logic [fwbc_pkg::VALUE_W-1:0] want,
                                       logic [fwbc_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      errors = errors + 1;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fwbc_pkg::out_item_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        cache_keys[i]   = '0;
        cache_values[i] = '0;
        cache_dirty[i]  = 1'b0;
      end
      ring_head    = '0;
      ring_count   = '0;
      capacity_reg = fwbc_pkg::CAP_W'(fwbc_pkg::CAP_RESET);
      due_results.delete();
    end else begin
      // A result never belongs to a request taken at the same edge, so the
      // result side is checked before new predictions are queued.
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result: expected none, actual %h %h %h %b",
                   $time, out_item.kind, out_item.out_key, out_item.out_value,
                   out_item.last);
        end else begin
          want = due_results.pop_front();
          report_field("kind", 64'(want.kind), 64'(out_item.kind));
          report_field("out_key", 64'(want.out_key), 64'(out_item.out_key));
          report_field("out_value", want.out_value, out_item.out_value);
          report_field("last", 64'(want.last), 64'(out_item.last));
        end
      end
      if (cfg_valid && cfg_ready) capacity_reg = cfg_data;
      if (in_valid && in_ready) predict_request(in_item);
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the FIFO write-back cache unit
// Sends directed and random get, set, fill and flush requests under several
// capacity settings, with random gaps on requests and stalls on results,
// and leaves the checking to the checker instance.
// ----------------------------------------------------------------------------
module testbench;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  fwbc_pkg::in_item_t         in_item   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  fwbc_pkg::out_item_t        out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [fwbc_pkg::CAP_W-1:0] cfg_data  = '0;

  int unsigned      errors;
  int unsigned      outstanding;
  bit               quiet = 1'b0;
  int unsigned      stall_left = 0;

  logic [fwbc_pkg::KEY_W-1:0] key_pool [20];
  int unsigned                pool_size;

  fifo_writeback_cache_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fwbc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("fifo_writeback_cache_unit regression: fail");
    $finish;
  end

  // Result side: random stall bursts on out_ready.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input fwbc_pkg::cmd_t cmd,
                              input logic [fwbc_pkg::KEY_W-1:0] key,
                              input logic [fwbc_pkg::VALUE_W-1:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{command: cmd, key: key, value: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The count from the checker is registered, hence the first wait.
  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [fwbc_pkg::CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [fwbc_pkg::VALUE_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [fwbc_pkg::KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // Mostly read-through pairs and writes over a key pool a little larger
  // than the capacity, so hits, refills and evictions all occur.
  task automatic random_phase(input logic [fwbc_pkg::CAP_W-1:0] cap,
                              input int unsigned count);
    int unsigned                sent;
    int unsigned                pick;
    logic [fwbc_pkg::KEY_W-1:0] key;
    sent = 0;
    pool_size = (cap == 0) ? 3 : ((cap > 16) ? 18 : cap + 2);
    for (int i = 0; i < 20; i++) key_pool[i] = $urandom;
    write_capacity(cap);
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      key  = pool_key();
      if (pick < 40) begin
        send_request(fwbc_pkg::CMD_GET, key, rand_value());
        send_request(fwbc_pkg::CMD_FILL, key, rand_value());
        sent += 2;
      end else if (pick < 70) begin
        send_request(fwbc_pkg::CMD_SET, key, rand_value());
        sent += 1;
      end else if (pick < 85) begin
        send_request(fwbc_pkg::CMD_GET, key, rand_value());
        sent += 1;
      end else if (pick < 90) begin
        send_request(fwbc_pkg::CMD_FLUSH, $urandom, rand_value());
        sent += 1;
      end else begin
        send_request(fwbc_pkg::cmd_t'($urandom_range(0, 3)), $urandom, rand_value());
        sent += 1;
      end
    end
    drain_results();
  endtask

  initial begin
    logic [fwbc_pkg::CAP_W-1:0] phase_caps [8];
    phase_caps = '{5'd3, 5'd17, 5'd1, 5'd16, 5'd8, 5'd31, 5'd0, 5'd12};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Basic hits, misses, updates in place and flushes at the reset capacity.
    send_request(fwbc_pkg::CMD_GET, 32'h0, 64'h0);
    send_request(fwbc_pkg::CMD_SET, 32'h0, 64'h0);
    send_request(fwbc_pkg::CMD_SET, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(fwbc_pkg::CMD_GET, 32'hffff_ffff, 64'h0);
    send_request(fwbc_pkg::CMD_GET, 32'h0, 64'hffff_ffff_ffff_ffff);
    send_request(fwbc_pkg::CMD_SET, 32'h0, 64'h0123_4567_89ab_cdef);
    send_request(fwbc_pkg::CMD_FILL, 32'hffff_ffff, 64'h5);
    send_request(fwbc_pkg::CMD_FILL, 32'h5a5a_a5a5, 64'hfeed_face_cafe_beef);
    send_request(fwbc_pkg::CMD_GET, 32'h0000_1234, 64'h0);
    send_request(fwbc_pkg::CMD_FLUSH, 32'h0, 64'h0);
    send_request(fwbc_pkg::CMD_FLUSH, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(fwbc_pkg::CMD_GET, 32'h0, 64'h0);
    drain_results();

    // Small capacity: dirty victims are written back, clean ones are not.
    write_capacity(5'd2);
    send_request(fwbc_pkg::CMD_SET, 32'h0000_00a1, 64'h11);
    send_request(fwbc_pkg::CMD_SET, 32'h0000_00b2, 64'h22);
    send_request(fwbc_pkg::CMD_FILL, 32'h0000_00c3, 64'h33);
    send_request(fwbc_pkg::CMD_FILL, 32'h0000_00d4, 64'h44);
    send_request(fwbc_pkg::CMD_SET, 32'h0000_00e5, 64'h55);
    drain_results();

    // An out-of-range capacity acts as the maximum; then a drop to zero,
    // which acts as one, evicts the whole backlog at the next append.
    write_capacity(5'd31);
    send_request(fwbc_pkg::CMD_SET, 32'h8000_0001, 64'h8000_0000_0000_0001);
    send_request(fwbc_pkg::CMD_FILL, 32'h8000_0002, 64'h2);
    send_request(fwbc_pkg::CMD_SET, 32'h8000_0003, 64'h3);
    send_request(fwbc_pkg::CMD_SET, 32'h8000_0004, 64'h4);
    drain_results();
    write_capacity(5'd0);
    send_request(fwbc_pkg::CMD_SET, 32'h8000_0005, 64'h5);
    send_request(fwbc_pkg::CMD_GET, 32'h8000_0005, 64'h0);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) quiet = 1'b1;
      random_phase(phase_caps[p], 16);
    end

    repeat (40) @(posedge clk);
    if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("fifo_writeback_cache_unit regression: pass");
    end else begin
      $display("fifo_writeback_cache_unit regression: fail");
    end
    $finish;
  end

endmodule
